>>> src/radial_fisheye_coordinate_remap_unit_defines.svh
// Assertion macros for the radial fisheye coordinate remap unit.
// Users must have signals named clk and rst_n in scope.
`ifndef RADIAL_FISHEYE_COORDINATE_REMAP_UNIT_DEFINES_SVH
`define RADIAL_FISHEYE_COORDINATE_REMAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFR_ASSERT_IMP(label, ante, cons, msg)
`define RFR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> src/rfr_pkg.sv
// Shared constants and helpers of the fisheye remap unit.
// No dependencies.
`default_nettype none
package rfr_pkg;
  localparam int COORD_W        = 12;
  localparam int DIM_CFG_W      = 13;
  localparam int OUT_W          = 14;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_DIM_DEF    = 4096;
  localparam int RATIO_FRAC_DEF = 16;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction
endpackage
`default_nettype wire

>>> src/rfr_if.sv
// Valid/ready channel interfaces for source and destination coordinate words.
// Depends on rfr_pkg.
`default_nettype none
interface rfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [rfr_pkg::COORD_W-1:0] src_x;
  logic [rfr_pkg::COORD_W-1:0] src_y;
  modport source (output valid, output src_x, output src_y, input ready);
  modport sink   (input valid, input src_x, input src_y, output ready);
endinterface

interface rfr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rfr_pkg::OUT_W-1:0] dst_x;
  logic signed [rfr_pkg::OUT_W-1:0] dst_y;
  logic                             inside_res;
  modport source (output valid, output dst_x, output dst_y, output inside_res, input ready);
  modport sink   (input valid, input dst_x, input dst_y, input inside_res, output ready);
endinterface
`default_nettype wire

>>> src/radial_fisheye_coordinate_remap_unit.sv
// Top level of the radial fisheye coordinate remap unit.
// Depends on rfr_pkg, rfr_if, rfr_sqrt_cell, rfr_div_cell and the defines header.
//
// The unit takes one source coordinate word per clock, unless the chain is held, and
// returns one destination word per source word, in order. Each word runs through a
// chain of registered cells: an offset stage, a squaring stage, one root cell per
// radius bit, one divider cell per quotient bit and one root cell per ratio bit,
// then a multiply stage and the output register. Throughput is one word per cycle
// while no hold is in force. The whole chain holds only when the last stage has a
// word and the output register holds an untaken one. Configuration writes take
// effect for words accepted after.
`default_nettype none
`include "radial_fisheye_coordinate_remap_unit_defines.svh"
module radial_fisheye_coordinate_remap_unit #(
  parameter int MAX_DIM         = rfr_pkg::MAX_DIM_DEF,
  parameter int RATIO_FRAC_BITS = rfr_pkg::RATIO_FRAC_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rfr_in_if.sink                             in_ch,
  rfr_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [rfr_pkg::DIM_CFG_W-1:0] cfg_wdata
);
  import rfr_pkg::*;

  localparam int F      = RATIO_FRAC_BITS;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int OFF_W  = max_int(COORD_W + 1, DIM_W) + 1;
  localparam int SQ_W   = 2 * OFF_W;
  localparam int NUM_W  = 8 + 2 * F;
  localparam int RAT_W  = NUM_W / 2;
  localparam int PROD_W = OFF_W + RAT_W + 2;
  localparam int SIDE1  = 2 * DIM_W + 2 * OFF_W;
  localparam int SIDE2  = SIDE1 + 1;
  localparam logic [NUM_W-1:0] NUM_C = NUM_W'(200) << (2 * F);
  localparam logic [PROD_W-1:0] RND_C = PROD_W'((64'd1 << (F + 1)) - 64'd1);

  // Configuration registers.
  logic [DIM_CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_CFG_W'(WIDTH_RESET);
      height_r <= DIM_CFG_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Chain enable: hold only when the last word cannot leave.
  logic vp_r, out_valid_r, adv;
  assign adv         = !(vp_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv;

  // Clamped dimensions and Q.1 offsets.
  logic [DIM_W-1:0]       w_in, h_in;
  logic signed [OFF_W-1:0] dx2_in, dy2_in;

  always_comb begin
    w_in = (32'(width_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_r);
    h_in = (32'(height_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_r);
    dx2_in = $signed({{(OFF_W-COORD_W-1){1'b0}}, in_ch.src_x, 1'b0})
           - $signed({{(OFF_W-DIM_W){1'b0}}, w_in});
    dy2_in = $signed({{(OFF_W-COORD_W-1){1'b0}}, in_ch.src_y, 1'b0})
           - $signed({{(OFF_W-DIM_W){1'b0}}, h_in});
  end

  // Offset stage.
  logic                    va_r;
  logic [DIM_W-1:0]        w_a_r, h_a_r;
  logic signed [OFF_W-1:0] dx2_a_r, dy2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_a_r   <= w_in;
      h_a_r   <= h_in;
      dx2_a_r <= dx2_in;
      dy2_a_r <= dy2_in;
    end
  end

  // Squaring stage.
  logic signed [SQ_W-1:0] sqx_nxt, sqy_nxt;
  logic                   vb_r;
  logic [SQ_W-1:0]        sqx_b_r, sqy_b_r;
  logic [SIDE1-1:0]       side_b_r;

  assign sqx_nxt = dx2_a_r * dx2_a_r;
  assign sqy_nxt = dy2_a_r * dy2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_b_r  <= $unsigned(sqx_nxt);
      sqy_b_r  <= $unsigned(sqy_nxt);
      side_b_r <= {w_a_r, h_a_r, dx2_a_r, dy2_a_r};
    end
  end

  // Radius root chain over the squared distance.
  logic             r_v    [0:OFF_W];
  logic [SQ_W-1:0]  r_val  [0:OFF_W];
  logic [OFF_W+1:0] r_rem  [0:OFF_W];
  logic [OFF_W-1:0] r_root [0:OFF_W];
  logic [SIDE1-1:0] r_side [0:OFF_W];

  assign r_v[0]    = vb_r;
  assign r_val[0]  = sqx_b_r + sqy_b_r;
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_side[0] = side_b_r;

  for (genvar k = 0; k < OFF_W; k++) begin : g_rad
    rfr_sqrt_cell #(.N(OFF_W), .SIDE_W(SIDE1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .valid_i(r_v[k]), .v_i(r_val[k]), .rem_i(r_rem[k]), .root_i(r_root[k]),
      .side_i(r_side[k]),
      .valid_o(r_v[k+1]), .v_o(r_val[k+1]), .rem_o(r_rem[k+1]), .root_o(r_root[k+1]),
      .side_o(r_side[k+1])
    );
  end

  // Divider chain: 200 << 2F over the radius, a zero radius divides by one.
  logic             zero_rad;
  logic             d_v    [0:NUM_W];
  logic [OFF_W-1:0] d_d    [0:NUM_W];
  logic [OFF_W-1:0] d_rem  [0:NUM_W];
  logic [NUM_W-1:0] d_q    [0:NUM_W];
  logic [SIDE2-1:0] d_side [0:NUM_W];

  assign zero_rad  = (r_root[OFF_W] == '0);
  assign d_v[0]    = r_v[OFF_W];
  assign d_d[0]    = zero_rad ? OFF_W'(1) : r_root[OFF_W];
  assign d_rem[0]  = '0;
  assign d_q[0]    = '0;
  assign d_side[0] = {r_side[OFF_W], zero_rad};

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    rfr_div_cell #(.DW(OFF_W), .QW(NUM_W), .SIDE_W(SIDE2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .valid_i(d_v[k]), .num_bit(NUM_C[NUM_W-1-k]), .d_i(d_d[k]), .rem_i(d_rem[k]),
      .q_i(d_q[k]), .side_i(d_side[k]),
      .valid_o(d_v[k+1]), .d_o(d_d[k+1]), .rem_o(d_rem[k+1]), .q_o(d_q[k+1]),
      .side_o(d_side[k+1])
    );
  end

  // Ratio root chain over the quotient.
  logic             q_v    [0:RAT_W];
  logic [NUM_W-1:0] q_val  [0:RAT_W];
  logic [RAT_W+1:0] q_rem  [0:RAT_W];
  logic [RAT_W-1:0] q_root [0:RAT_W];
  logic [SIDE2-1:0] q_side [0:RAT_W];

  assign q_v[0]    = d_v[NUM_W];
  assign q_val[0]  = d_q[NUM_W];
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_side[0] = d_side[NUM_W];

  for (genvar k = 0; k < RAT_W; k++) begin : g_rat
    rfr_sqrt_cell #(.N(RAT_W), .SIDE_W(SIDE2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .valid_i(q_v[k]), .v_i(q_val[k]), .rem_i(q_rem[k]), .root_i(q_root[k]),
      .side_i(q_side[k]),
      .valid_o(q_v[k+1]), .v_o(q_val[k+1]), .rem_o(q_rem[k+1]), .root_o(q_root[k+1]),
      .side_o(q_side[k+1])
    );
  end

  // Multiply stage: offsets times the ratio.
  logic [SIDE2-1:0]         qs;
  logic signed [OFF_W-1:0]  dx2_q, dy2_q;
  logic signed [PROD_W-1:0] px_nxt, py_nxt;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic [DIM_W-1:0]         w_p_r, h_p_r;
  logic                     zero_p_r;

  assign qs     = q_side[RAT_W];
  assign dx2_q  = $signed(qs[2*OFF_W:OFF_W+1]);
  assign dy2_q  = $signed(qs[OFF_W:1]);
  assign px_nxt = dx2_q * $signed({1'b0, q_root[RAT_W]});
  assign py_nxt = dy2_q * $signed({1'b0, q_root[RAT_W]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (adv) begin
      vp_r <= q_v[RAT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      w_p_r    <= qs[SIDE2-1:SIDE2-DIM_W];
      h_p_r    <= qs[SIDE2-DIM_W-1:2*OFF_W+1];
      zero_p_r <= qs[0];
    end
  end

  // Add the centre, truncate toward zero and check the bounds.
  logic signed [PROD_W-1:0] wq, hq, numx, numy, nx, ny, wext, hext;
  logic                     inside_nxt;

  always_comb begin
    wext = $signed({{(PROD_W-DIM_W){1'b0}}, w_p_r});
    hext = $signed({{(PROD_W-DIM_W){1'b0}}, h_p_r});
    wq   = $signed({{(PROD_W-DIM_W-F){1'b0}}, w_p_r, {F{1'b0}}});
    hq   = $signed({{(PROD_W-DIM_W-F){1'b0}}, h_p_r, {F{1'b0}}});
    numx = wq + px_r;
    numy = hq + py_r;
    if (numx[PROD_W-1]) numx = numx + $signed(RND_C);
    if (numy[PROD_W-1]) numy = numy + $signed(RND_C);
    if (zero_p_r) begin
      nx = wext >>> 1;
      ny = hext >>> 1;
    end else begin
      nx = numx >>> (F + 1);
      ny = numy >>> (F + 1);
    end
    inside_nxt = !nx[PROD_W-1] && (nx < wext) && !ny[PROD_W-1] && (ny < hext);
  end

  // Output register.
  logic signed [OUT_W-1:0] dst_x_r, dst_y_r;
  logic                    inside_r;
  logic                    out_load;

  assign out_load = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dst_x_r  <= nx[OUT_W-1:0];
      dst_y_r  <= ny[OUT_W-1:0];
      inside_r <= inside_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dst_x      = dst_x_r;
  assign out_ch.dst_y      = dst_y_r;
  assign out_ch.inside_res = inside_r;

  // Checks on the chain control.
  `RFR_ASSERT_NXT(a_accept_enters, in_ch.valid && in_ch.ready, va_r,
                  "accepted word did not enter the offset stage")
  `RFR_ASSERT_NXT(a_last_held, vp_r && !adv, vp_r && $stable(px_r),
                  "last stage lost its word during a hold")
  `RFR_ASSERT_NXT(a_out_held, out_valid_r && !out_ch.ready,
                  out_valid_r && $stable(dst_x_r) && $stable(inside_r),
                  "untaken result changed")
  `RFR_ASSERT_IMP(a_zero_center, vp_r && zero_p_r, nx == (wext >>> 1),
                  "zero radius word does not map to the centre")
endmodule
`default_nettype wire

>>> src/rfr_sqrt_cell.sv
// One registered digit step of a pipelined integer square root.
// Standalone cell; chained N deep for an N-bit root.
`default_nettype none
module rfr_sqrt_cell #(
  parameter int N      = 14,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire logic [2*N-1:0]    v_i,
  input  wire logic [N+1:0]      rem_i,
  input  wire logic [N-1:0]      root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic      [2*N-1:0]    v_o,
  output logic      [N+1:0]      rem_o,
  output logic      [N-1:0]      root_o,
  output logic      [SIDE_W-1:0] side_o
);
  logic              valid_r;
  logic [2*N-1:0]    v_r;
  logic [N+1:0]      rem_r, rem_nxt;
  logic [N-1:0]      root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [N+3:0]      cur, trial;

  // Bring down the next two bits and try the next root bit.
  always_comb begin
    cur   = {rem_i, v_i[2*N-1:2*N-2]};
    trial = {2'b00, root_i, 2'b01};
    if (cur >= trial) begin
      rem_nxt  = (N+2)'(cur - trial);
      root_nxt = {root_i[N-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[N+1:0];
      root_nxt = {root_i[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= {v_i[2*N-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign v_o     = v_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;
endmodule
`default_nettype wire

>>> src/rfr_div_cell.sv
// One registered bit step of a pipelined restoring divider.
// Standalone cell; chained once per quotient bit.
`default_nettype none
module rfr_div_cell #(
  parameter int DW     = 14,
  parameter int QW     = 40,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire logic              num_bit,
  input  wire logic [DW-1:0]     d_i,
  input  wire logic [DW-1:0]     rem_i,
  input  wire logic [QW-1:0]     q_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic      [DW-1:0]     d_o,
  output logic      [DW-1:0]     rem_o,
  output logic      [QW-1:0]     q_o,
  output logic      [SIDE_W-1:0] side_o
);
  logic              valid_r;
  logic [DW-1:0]     d_r, rem_r, rem_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [DW:0]       cur;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    cur = {rem_i, num_bit};
    if (cur >= {1'b0, d_i}) begin
      rem_nxt = DW'(cur - {1'b0, d_i});
      q_nxt   = {q_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt = cur[DW-1:0];
      q_nxt   = {q_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;
  assign rem_o   = rem_r;
  assign q_o     = q_r;
  assign side_o  = side_r;
endmodule
`default_nettype wire
